// File: hw/rtl/rde_pkg.sv
package rde_pkg;

    // number width actually converted; bits above are ignored
    localparam int VALUE_WIDTH = 64;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;
    localparam int POS_W   = 6;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_OFFSET = 7'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: hw/rtl/rde_in_if.sv
interface rde_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: hw/rtl/rde_out_if.sv
interface rde_out_if;
    logic                          valid;
    logic                          ready;
    logic [rde_pkg::DIGIT_W-1:0]   digit_value;
    logic [rde_pkg::CHAR_W-1:0]    digit_char;
    logic [rde_pkg::POS_W-1:0]     position;
    logic                          last_digit;

    modport source (output valid, output digit_value, output digit_char,
                    output position, output last_digit, input ready);
    modport sink   (input valid, input digit_value, input digit_char,
                    input position, input last_digit, output ready);
endinterface

// File: hw/rtl/rde_cfg_if.sv
interface rde_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rde_pkg::DIGIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/rde_div.sv
module rde_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rde_pkg::t_div_ctrl                i_ctrl,
    input  logic [rde_pkg::VALUE_WIDTH-1:0]   i_dividend,
    input  logic [rde_pkg::DIGIT_W-1:0]       i_base,
    output rde_pkg::t_div_stat                o_stat,
    output logic [rde_pkg::VALUE_WIDTH-1:0]   o_quotient,
    output logic [rde_pkg::DIGIT_W-1:0]       o_remainder
);

    localparam int W = rde_pkg::VALUE_WIDTH;
    localparam logic [rde_pkg::CNT_W-1:0] CNT_LAST = rde_pkg::CNT_W'(W - 1);

    logic [W-1:0]                  r_num, n_num;
    logic [rde_pkg::DIGIT_W-1:0]   r_rem, n_rem;
    logic [rde_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;

    logic [rde_pkg::DIGIT_W:0]     trial;
    logic [rde_pkg::DIGIT_W-1:0]   diff;
    logic                          ge;

    // one restoring step: shift in next dividend bit, subtract base if it fits
    assign trial = {r_rem, r_num[W-1]};
    assign ge    = trial >= {1'b0, i_base};
    assign diff  = trial[rde_pkg::DIGIT_W-1:0] - i_base;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            n_num  = i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[W-2:0], ge};
            n_rem = ge ? diff : trial[rde_pkg::DIGIT_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_num;
    assign o_remainder  = r_rem;

endmodule

// File: hw/rtl/radix_digit_emitter.sv
// channel   dir  handshake        payload
// i_in      in   valid / ready    value (64 bits, low VALUE_WIDTH bits used)
// o_out     out  valid / ready    digit_value, digit_char, position, last_digit
// i_cfg     in   valid / ready    data: radix (6 bits)
//
// each digit comes from one pass of the single shared bit-serial
// restoring divider, so a number of n digits takes n passes
// synchronous active-low reset; radix returns to 10
// a digit waiting on o_out stalls the divider until it is taken; the
// next number is accepted while the last digit still waits
module radix_digit_emitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rde_in_if.sink           i_in,
    rde_out_if.source        o_out,
    rde_cfg_if.sink          i_cfg
);

    localparam int W = rde_pkg::VALUE_WIDTH;

    // configuration
    logic [rde_pkg::DIGIT_W-1:0] r_radix;
    logic [rde_pkg::DIGIT_W-1:0] base;

    // sequencer
    rde_pkg::t_state r_state, n_state;

    // digit position of the division in flight
    logic [rde_pkg::POS_W-1:0] r_pos, n_pos;

    // output register
    logic                        r_ov, n_ov;
    logic [rde_pkg::DIGIT_W-1:0] r_dv, n_dv;
    logic [rde_pkg::POS_W-1:0]   r_opos, n_opos;
    logic                        r_last, n_last;

    // divider
    rde_pkg::t_div_ctrl          div_ctrl;
    rde_pkg::t_div_stat          div_stat;
    logic [W-1:0]                div_dividend;
    logic [W-1:0]                div_quot;
    logic [rde_pkg::DIGIT_W-1:0] div_rem;

    logic in_xfer;
    logic out_xfer;
    logic result_ready;   // a finished digit sits in the divider
    logic out_free;       // output register can take a digit this cycle
    logic load;           // move the finished digit into the output register
    logic quot_zero;
    logic in_ready;

    // radix clamp: 0 and 1 act as base 2, above 36 acts as base 36
    always_comb begin
        if (r_radix < rde_pkg::RADIX_MIN) begin
            base = rde_pkg::RADIX_MIN;
        end else if (r_radix > rde_pkg::RADIX_MAX) begin
            base = rde_pkg::RADIX_MAX;
        end else begin
            base = r_radix;
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rde_pkg::RADIX_RESET;
        end else if (i_cfg.valid) begin
            r_radix <= i_cfg.data;
        end
    end

    assign in_xfer      = i_in.valid && in_ready;
    assign out_xfer     = r_ov && o_out.ready;
    assign out_free     = !r_ov || out_xfer;
    assign result_ready = (r_state == rde_pkg::ST_DIVIDE && div_stat.done) ||
                          (r_state == rde_pkg::ST_HOLD);
    assign quot_zero    = (div_quot == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            rde_pkg::ST_IDLE: begin
                if (i_in.valid) n_state = rde_pkg::ST_DIVIDE;
            end
            rde_pkg::ST_DIVIDE, rde_pkg::ST_HOLD: begin
                if (result_ready) begin
                    if (!out_free) begin
                        n_state = rde_pkg::ST_HOLD;
                    end else if (quot_zero) begin
                        // most significant digit is out, number done
                        n_state = rde_pkg::ST_IDLE;
                    end else begin
                        n_state = rde_pkg::ST_DIVIDE;
                    end
                end
            end
            default: n_state = rde_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready       = 1'b0;
        load           = 1'b0;
        div_ctrl.start = 1'b0;
        div_dividend   = div_quot;
        unique case (r_state) inside
            rde_pkg::ST_IDLE: begin
                in_ready       = 1'b1;
                div_ctrl.start = i_in.valid;
                div_dividend   = i_in.value[W-1:0];
            end
            rde_pkg::ST_DIVIDE, rde_pkg::ST_HOLD: begin
                if (result_ready && out_free) begin
                    load           = 1'b1;
                    div_ctrl.start = !quot_zero;
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_in.ready = in_ready;

    // position and output register
    always_comb begin
        n_pos  = r_pos;
        n_ov   = r_ov;
        n_dv   = r_dv;
        n_opos = r_opos;
        n_last = r_last;
        if (out_xfer) n_ov = 1'b0;
        if (in_xfer) n_pos = '0;
        if (load) begin
            n_ov   = 1'b1;
            n_dv   = div_rem;
            n_opos = r_pos;
            n_last = quot_zero;
            n_pos  = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rde_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv   <= n_dv;
        r_opos <= n_opos;
        r_last <= n_last;
    end

    rde_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (div_ctrl),
        .i_dividend  (div_dividend),
        .i_base      (base),
        .o_stat      (div_stat),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    assign o_out.valid       = r_ov;
    assign o_out.digit_value = r_dv;
    assign o_out.digit_char  = {1'b0, r_dv} + rde_pkg::CHAR_OFFSET;
    assign o_out.position    = r_opos;
    assign o_out.last_digit  = r_last;

`ifndef SYNTH
    // a new number only enters while the divider is free
    a_in_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> !div_stat.busy)
        else $error("input transfer while divider busy");

    // holding a finished digit means the output register is occupied
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rde_pkg::ST_HOLD) |-> r_ov)
        else $error("hold state with empty output register");

    // loading the last digit ends the number and leaves the divider idle
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && quot_zero) |=> (r_state == rde_pkg::ST_IDLE) && !div_stat.busy)
        else $error("sequencer kept running after last digit");
`endif

endmodule
